>>> rtl/cdsm_pkg.sv
// shared constants, types and codes for the decreasing subsequence counter
`timescale 1ns / 1ps

package cdsm_pkg;

    // store depth and derived widths
    localparam int NUM_CODES = 676;
    localparam int CODE_W    = 10;
    localparam int COUNT_W   = 30;
    localparam int ADDR_W    = (NUM_CODES > 1) ? $clog2(NUM_CODES) : 1;
    localparam int CMP_W     = ((ADDR_W > CODE_W) ? ADDR_W : CODE_W) + 1;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [CODE_W-1:0]  code_t;

    localparam count_t MODULUS   = COUNT_W'(1000000007);
    localparam count_t COUNT_ONE = COUNT_W'(1);
    localparam addr_t  ADDR_LAST = ADDR_W'(NUM_CODES - 1);
    localparam addr_t  ADDR_ZERO = ADDR_W'(0);

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_LAST,
        ST_TOTAL,
        ST_PUSH
    } state_t;

    // count store access from the sequencer
    typedef struct packed {
        logic   rd_en;
        addr_t  rd_addr;
        logic   wr_en;
        addr_t  wr_addr;
        count_t wr_data;
    } mem_ctl_t;

endpackage

>>> rtl/cdsm_addmod.sv
// shared modular adder: sum of two residues reduced once
`timescale 1ns / 1ps

module cdsm_addmod
    import cdsm_pkg::*;
(
    input  count_t op_a,
    input  count_t op_b,
    output count_t sum
);

    logic [COUNT_W:0] raw;
    logic [COUNT_W:0] red;

    // add, then subtract the modulus once if the sum reached it
    always_comb begin
        raw = {1'b0, op_a} + {1'b0, op_b};
        red = raw - {1'b0, MODULUS};
        if (raw >= {1'b0, MODULUS}) begin
            sum = red[COUNT_W-1:0];
        end else begin
            sum = raw[COUNT_W-1:0];
        end
    end

endmodule

>>> rtl/cdsm_store.sv
// per-code count memory, one write and one registered read port
`timescale 1ns / 1ps

module cdsm_store
    import cdsm_pkg::*;
(
    input  logic     aclk,
    input  mem_ctl_t ctl,
    output count_t   rd_data
);

    count_t mem [NUM_CODES];
    count_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[ctl.wr_addr] <= ctl.wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_data_reg <= mem[ctl.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/cdsm_ctrl.sv
// sequencer and datapath registers around the shared modular adder
`timescale 1ns / 1ps

module cdsm_ctrl
    import cdsm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  code_t    s_item_code,
    input  logic     s_start_new,
    output logic     m_valid,
    input  logic     m_ready,
    output count_t   m_running_count,
    output mem_ctl_t mem_ctl,
    input  count_t   mem_rd_data
);

    state_t state_reg, state_next;
    addr_t  addr_reg, addr_next;
    addr_t  code_reg, code_next;
    logic   hit_reg, hit_next;
    logic   boot_reg, boot_next;
    logic   acc_pend_reg, acc_pend_next;
    count_t n_reg, n_next;
    count_t total_reg, total_next;
    logic   m_valid_reg, m_valid_next;
    count_t m_data_reg, m_data_next;

    logic   accept;
    logic   code_hit;
    addr_t  code_addr;
    logic [CMP_W-1:0] code_ext;
    logic   at_code;
    logic   out_free;
    count_t add_a, add_b, add_sum;

    // incoming code range check and store address
    always_comb begin
        code_ext  = CMP_W'(s_item_code);
        code_hit  = (code_ext < CMP_W'(NUM_CODES));
        code_addr = code_ext[ADDR_W-1:0];
    end

    assign accept   = s_valid && s_ready;
    assign at_code  = (addr_reg == code_reg);
    assign out_free = !m_valid_reg || m_ready;

    cdsm_addmod u_addmod (
        .op_a (add_a),
        .op_b (add_b),
        .sum  (add_sum)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (addr_reg == ADDR_LAST) begin
                    if (boot_reg) begin
                        state_next = ST_IDLE;
                    end else if (hit_reg) begin
                        state_next = ST_TOTAL;
                    end else begin
                        state_next = ST_PUSH;
                    end
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_start_new) begin
                        state_next = ST_CLEAR;
                    end else if (code_hit) begin
                        state_next = ST_SWEEP;
                    end else begin
                        state_next = ST_PUSH;
                    end
                end
            end
            ST_SWEEP: begin
                if (at_code) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:  state_next = ST_TOTAL;
            ST_TOTAL: state_next = ST_PUSH;
            ST_PUSH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs: handshake, store access and adder operands
    always_comb begin
        s_ready         = 1'b0;
        mem_ctl.rd_en   = 1'b0;
        mem_ctl.rd_addr = addr_reg;
        mem_ctl.wr_en   = 1'b0;
        mem_ctl.wr_addr = addr_reg;
        mem_ctl.wr_data = '0;
        add_a           = n_reg;
        add_b           = mem_rd_data;
        case (state_reg)
            ST_CLEAR: begin
                mem_ctl.wr_en = 1'b1;
                if (hit_reg && at_code) begin
                    mem_ctl.wr_data = COUNT_ONE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_SWEEP: begin
                mem_ctl.rd_en = 1'b1;
            end
            ST_LAST: begin
                mem_ctl.wr_en   = 1'b1;
                mem_ctl.wr_addr = code_reg;
                mem_ctl.wr_data = add_sum;
                add_a           = mem_rd_data;
                add_b           = n_reg;
            end
            ST_TOTAL: begin
                add_a = total_reg;
                add_b = n_reg;
            end
            ST_PUSH: begin
                s_ready = 1'b0;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        addr_next     = addr_reg;
        code_next     = code_reg;
        hit_next      = hit_reg;
        boot_next     = boot_reg;
        acc_pend_next = 1'b0;
        n_next        = n_reg;
        total_next    = total_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        case (state_reg)
            ST_CLEAR: begin
                addr_next = addr_reg + ADDR_W'(1);
                if (addr_reg == ADDR_LAST) begin
                    boot_next = 1'b0;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    code_next = code_addr;
                    hit_next  = code_hit;
                    n_next    = COUNT_ONE;
                    if (s_start_new) begin
                        addr_next  = ADDR_ZERO;
                        total_next = COUNT_ONE;
                    end else begin
                        addr_next = ADDR_LAST;
                    end
                end
            end
            ST_SWEEP: begin
                // fold in the word read last cycle for a code above the item
                if (acc_pend_reg) begin
                    n_next = add_sum;
                end
                acc_pend_next = !at_code;
                if (!at_code) begin
                    addr_next = addr_reg - ADDR_W'(1);
                end
            end
            ST_TOTAL: begin
                total_next = add_sum;
            end
            ST_PUSH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = total_reg;
                end
            end
            default: begin
                acc_pend_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            addr_reg     <= ADDR_ZERO;
            hit_reg      <= 1'b0;
            boot_reg     <= 1'b1;
            acc_pend_reg <= 1'b0;
            total_reg    <= COUNT_ONE;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            hit_reg      <= hit_next;
            boot_reg     <= boot_next;
            acc_pend_reg <= acc_pend_next;
            total_reg    <= total_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        code_reg   <= code_next;
        n_reg      <= n_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_running_count = m_data_reg;

    // sweep never passes below the item's own code
    a_sweep_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SWEEP |-> addr_reg >= code_reg)
        else $error("sweep address below item code");

    // the entry update never overlaps a pending accumulate
    a_last_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LAST |-> !acc_pend_reg)
        else $error("accumulate pending at entry update");

    // running total stays reduced
    a_total_range: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg < MODULUS)
        else $error("running total not reduced");

    // a finished word reaches the output register
    a_push_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUSH && out_free) |=> (m_valid_reg && m_data_reg == $past(total_reg)))
        else $error("result word not loaded");

endmodule

>>> rtl/count_decreasing_subsequences_mod_top.sv
// Path to m_valid: an in-range code c sweeps the count memory from its top entry down to c,
// then passes ST_LAST, ST_TOTAL and ST_PUSH; an item with start_new first clears every
// entry, and an out-of-range code goes straight to ST_PUSH. One word at a time: the serial
// sweep of the count memory through its single read port and the shared modular adder
// sets the rate. Reset: synchronous active-low aresetn, then a clearing pass over all
// NUM_CODES entries (one a cycle) before s_ready first rises; the running total restarts at one.
`timescale 1ns / 1ps

module count_decreasing_subsequences_mod_top
    import cdsm_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  code_t  s_item_code,
    input  logic   s_start_new,
    output logic   m_valid,
    input  logic   m_ready,
    output count_t m_running_count
);

    mem_ctl_t mem_ctl;
    count_t   mem_rd_data;

    // sequencer with the shared adder
    cdsm_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_item_code     (s_item_code),
        .s_start_new     (s_start_new),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_running_count (m_running_count),
        .mem_ctl         (mem_ctl),
        .mem_rd_data     (mem_rd_data)
    );

    // per-code count memory
    cdsm_store u_store (
        .aclk    (aclk),
        .ctl     (mem_ctl),
        .rd_data (mem_rd_data)
    );

endmodule
